>>> hdl/clns_pkg.sv
// shared types, codes and the write sequence table for the character lcd nibble sequencer
// no dependencies; imported by clns_ctrl, clns_dpath and char_lcd_nibble_sequencer
`timescale 1ns / 1ps
`default_nettype none

package clns_pkg;

	// command codes on the input channel
	localparam logic [2:0] CMD_INIT     = 3'd0;
	localparam logic [2:0] CMD_CLEAR    = 3'd1;
	localparam logic [2:0] CMD_SET_LINE = 3'd2;
	localparam logic [2:0] CMD_WR_CHAR  = 3'd3;
	localparam logic [2:0] CMD_SHUTDOWN = 3'd4;

	// configuration register indexes
	localparam logic CFG_PULSE_WAIT  = 1'b0;
	localparam logic CFG_SETTLE_WAIT = 1'b1;

	localparam logic [7:0]  PULSE_WAIT_RST  = 8'd40;
	localparam logic [11:0] SETTLE_WAIT_RST = 12'd1600;

	// write targets
	localparam logic TGT_PORT = 1'b0;
	localparam logic TGT_DIR  = 1'b1;

	// expander port bits
	localparam logic [5:0] PIN_DB4 = 6'h01;
	localparam logic [5:0] PIN_DB6 = 6'h04;
	localparam logic [5:0] PIN_DB7 = 6'h08;
	localparam logic [5:0] PIN_RS  = 6'h10;
	localparam logic [5:0] PIN_E   = 6'h20;

	// enable pulse takes five sequencer steps
	localparam logic [2:0] PULSE_LAST = 3'd4;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_RUN
	} state_t;

	// sequence table ops
	typedef enum logic [3:0] {
		OP_DIR,
		OP_PUT,
		OP_SETB,
		OP_SETL,
		OP_SETC,
		OP_SHADOW,
		OP_PULSE,
		OP_WAIT_S,
		OP_END
	} op_t;

	// datapath actions, one per cycle
	typedef enum logic [3:0] {
		ACT_NONE,
		ACT_DIR,
		ACT_PUT,
		ACT_SETB,
		ACT_SETL,
		ACT_SETC,
		ACT_SHADOW,
		ACT_EHI,
		ACT_ELO,
		ACT_WAIT_P,
		ACT_WAIT_S,
		ACT_FINISH
	} act_t;

	typedef struct packed {
		op_t        op;
		logic [5:0] data;
	} rom_t;

	typedef struct packed {
		act_t       act;
		logic [5:0] data;
		logic       load;
	} ctl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_sts_t;

	localparam logic [5:0] PC_INIT     = 6'd0;
	localparam logic [5:0] PC_CLEAR    = 6'd18;
	localparam logic [5:0] PC_SET_LINE = 6'd24;
	localparam logic [5:0] PC_WR_CHAR  = 6'd31;
	localparam logic [5:0] PC_SHUTDOWN = 6'd44;

	function automatic logic [5:0] seq_start(input logic [2:0] cmd);
		logic [5:0] pc;
		case (cmd)
			CMD_INIT:     pc = PC_INIT;
			CMD_CLEAR:    pc = PC_CLEAR;
			CMD_SET_LINE: pc = PC_SET_LINE;
			CMD_WR_CHAR:  pc = PC_WR_CHAR;
			CMD_SHUTDOWN: pc = PC_SHUTDOWN;
			default:      pc = PC_INIT;
		endcase
		return pc;
	endfunction

	// OP_SETC data is the char bit index; OP_SETB and OP_SETL data is the port mask
	function automatic rom_t seq_rom(input logic [5:0] pc);
		rom_t e;
		case (pc)
			// init
			6'd0:  e = '{OP_DIR,    6'h00};
			6'd1:  e = '{OP_WAIT_S, 6'h00};
			6'd2:  e = '{OP_SHADOW, 6'h03};
			6'd3:  e = '{OP_PULSE,  6'h00};
			6'd4:  e = '{OP_PULSE,  6'h00};
			6'd5:  e = '{OP_PULSE,  6'h00};
			6'd6:  e = '{OP_PUT,    6'h02};
			6'd7:  e = '{OP_PULSE,  6'h00};
			6'd8:  e = '{OP_PUT,    6'h00};
			6'd9:  e = '{OP_PULSE,  6'h00};
			6'd10: e = '{OP_PUT,    6'h0C};
			6'd11: e = '{OP_PULSE,  6'h00};
			6'd12: e = '{OP_PUT,    6'h00};
			6'd13: e = '{OP_PULSE,  6'h00};
			6'd14: e = '{OP_PUT,    PIN_DB4};
			6'd15: e = '{OP_PULSE,  6'h00};
			6'd16: e = '{OP_WAIT_S, 6'h00};
			6'd17: e = '{OP_END,    6'h00};
			// clear
			6'd18: e = '{OP_PUT,    6'h00};
			6'd19: e = '{OP_PULSE,  6'h00};
			6'd20: e = '{OP_PUT,    PIN_DB4};
			6'd21: e = '{OP_PULSE,  6'h00};
			6'd22: e = '{OP_WAIT_S, 6'h00};
			6'd23: e = '{OP_END,    6'h00};
			// set line
			6'd24: e = '{OP_PUT,    6'h00};
			6'd25: e = '{OP_SETB,   PIN_DB7};
			6'd26: e = '{OP_SETL,   PIN_DB6};
			6'd27: e = '{OP_PULSE,  6'h00};
			6'd28: e = '{OP_PUT,    6'h00};
			6'd29: e = '{OP_PULSE,  6'h00};
			6'd30: e = '{OP_END,    6'h00};
			// write character, high nibble then low nibble
			6'd31: e = '{OP_PUT,    PIN_RS};
			6'd32: e = '{OP_SETC,   6'd4};
			6'd33: e = '{OP_SETC,   6'd5};
			6'd34: e = '{OP_SETC,   6'd6};
			6'd35: e = '{OP_SETC,   6'd7};
			6'd36: e = '{OP_PULSE,  6'h00};
			6'd37: e = '{OP_PUT,    PIN_RS};
			6'd38: e = '{OP_SETC,   6'd0};
			6'd39: e = '{OP_SETC,   6'd1};
			6'd40: e = '{OP_SETC,   6'd2};
			6'd41: e = '{OP_SETC,   6'd3};
			6'd42: e = '{OP_PULSE,  6'h00};
			6'd43: e = '{OP_END,    6'h00};
			// shutdown: clear, then the 4-bit function set nibble
			6'd44: e = '{OP_PUT,    6'h00};
			6'd45: e = '{OP_PULSE,  6'h00};
			6'd46: e = '{OP_PUT,    PIN_DB4};
			6'd47: e = '{OP_PULSE,  6'h00};
			6'd48: e = '{OP_WAIT_S, 6'h00};
			6'd49: e = '{OP_PUT,    6'h02};
			6'd50: e = '{OP_PULSE,  6'h00};
			6'd51: e = '{OP_END,    6'h00};
			default: e = '{OP_END,  6'h00};
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

>>> hdl/clns_ctrl.sv
// sequencer control: state machine stepping through the write sequence table
// depends on clns_pkg; drives clns_dpath through ctl_cmd_t
`timescale 1ns / 1ps
`default_nettype none

module clns_ctrl import clns_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [2:0] command,
	input  wire dp_sts_t    sts,
	output ctl_cmd_t        cmd
);

	state_t     state_q, state_d;
	logic [5:0] pc_q;
	logic [2:0] phase_q;
	rom_t       entry;
	act_t       act_c;
	logic       needs_port;
	logic       step;
	logic       accept;
	logic       cmd_ok;

	assign entry  = seq_rom(pc_q);
	assign cmd_ok = (command <= CMD_SHUTDOWN);
	assign accept = in_valid && in_ready;

	// expand table op into a single datapath action
	always_comb begin
		case (entry.op)
			OP_DIR:    act_c = ACT_DIR;
			OP_PUT:    act_c = ACT_PUT;
			OP_SETB:   act_c = ACT_SETB;
			OP_SETL:   act_c = ACT_SETL;
			OP_SETC:   act_c = ACT_SETC;
			OP_SHADOW: act_c = ACT_SHADOW;
			OP_WAIT_S: act_c = ACT_WAIT_S;
			OP_END:    act_c = ACT_FINISH;
			OP_PULSE: begin
				case (phase_q)
					3'd1:    act_c = ACT_EHI;
					3'd3:    act_c = ACT_ELO;
					default: act_c = ACT_WAIT_P;
				endcase
			end
			default:   act_c = ACT_NONE;
		endcase
	end

	always_comb begin
		case (act_c)
			ACT_DIR, ACT_PUT, ACT_SETB, ACT_SETL, ACT_SETC,
			ACT_EHI, ACT_ELO, ACT_FINISH: needs_port = 1'b1;
			default:                      needs_port = 1'b0;
		endcase
	end

	// writes wait while the output register is full
	assign step = (state_q == ST_RUN) && !(needs_port && !sts.out_free);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd_ok)
					state_d = ST_RUN;
			end
			ST_RUN: begin
				if (step && act_c == ACT_FINISH)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		cmd.act  = step ? act_c : ACT_NONE;
		cmd.data = entry.data;
		cmd.load = accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q    <= PC_INIT;
			phase_q <= 3'd0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				pc_q    <= seq_start(command);
				phase_q <= 3'd0;
			end else if (step) begin
				if (entry.op == OP_PULSE && phase_q != PULSE_LAST) begin
					phase_q <= phase_q + 3'd1;
				end else begin
					phase_q <= 3'd0;
					pc_q    <= pc_q + 6'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> hdl/clns_dpath.sv
// sequencer datapath: timing registers, port shadow, pending write and output register
// depends on clns_pkg; commanded by clns_ctrl
`timescale 1ns / 1ps
`default_nettype none

module clns_dpath import clns_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_index,
	input  wire logic [11:0] cfg_data,
	input  wire logic [7:0]  char_code,
	input  wire logic        line_select,
	input  wire ctl_cmd_t    cmd,
	output dp_sts_t          sts,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             write_target,
	output logic [5:0]       port_value,
	output logic [12:0]      hold_us,
	output logic             last_write
);

	logic [7:0]  pulse_wait_q;
	logic [11:0] settle_wait_q;
	logic [5:0]  shadow_q;
	logic [7:0]  char_q;
	logic        line_q;

	// pending write: its hold keeps growing until the next write shows up
	logic        stg_valid_q;
	logic        stg_target_q;
	logic [5:0]  stg_value_q;
	logic [12:0] stg_hold_q;

	logic        out_valid_q;
	logic        out_target_q;
	logic [5:0]  out_value_q;
	logic [12:0] out_hold_q;
	logic        out_last_q;

	logic        emit_c;
	logic        emit_target_c;
	logic [5:0]  emit_value_c;
	logic [12:0] wait_add_c;
	logic        finish_c;
	logic        push_c;

	always_comb begin
		emit_c        = 1'b0;
		emit_target_c = TGT_PORT;
		emit_value_c  = shadow_q;
		case (cmd.act)
			ACT_DIR: begin
				emit_c        = 1'b1;
				emit_target_c = TGT_DIR;
				emit_value_c  = 6'h00;
			end
			ACT_PUT: begin
				emit_c       = 1'b1;
				emit_value_c = cmd.data;
			end
			ACT_SETB: begin
				emit_c       = 1'b1;
				emit_value_c = shadow_q | cmd.data;
			end
			ACT_SETL: begin
				emit_c       = line_q;
				emit_value_c = shadow_q | cmd.data;
			end
			ACT_SETC: begin
				// char bit k drives data line k mod 4
				emit_c       = char_q[cmd.data[2:0]];
				emit_value_c = shadow_q | (PIN_DB4 << cmd.data[1:0]);
			end
			ACT_EHI: begin
				emit_c       = 1'b1;
				emit_value_c = shadow_q | PIN_E;
			end
			ACT_ELO: begin
				emit_c       = 1'b1;
				emit_value_c = shadow_q & ~PIN_E;
			end
			default: begin
				emit_c = 1'b0;
			end
		endcase
	end

	always_comb begin
		case (cmd.act)
			ACT_WAIT_P: wait_add_c = {5'd0, pulse_wait_q};
			ACT_WAIT_S: wait_add_c = {1'b0, settle_wait_q};
			default:    wait_add_c = 13'd0;
		endcase
	end

	assign finish_c     = (cmd.act == ACT_FINISH);
	assign push_c       = stg_valid_q && (emit_c || finish_c);
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign write_target = out_target_q;
	assign port_value   = out_value_q;
	assign hold_us      = out_hold_q;
	assign last_write   = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_wait_q  <= PULSE_WAIT_RST;
			settle_wait_q <= SETTLE_WAIT_RST;
			shadow_q      <= 6'h00;
			stg_valid_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_PULSE_WAIT:  pulse_wait_q  <= cfg_data[7:0];
					CFG_SETTLE_WAIT: settle_wait_q <= cfg_data;
					default:         pulse_wait_q  <= pulse_wait_q;
				endcase
			end
			if (cmd.act == ACT_SHADOW)
				shadow_q <= cmd.data;
			else if (emit_c && emit_target_c == TGT_PORT)
				shadow_q <= emit_value_c;
			if (emit_c)
				stg_valid_q <= 1'b1;
			else if (finish_c)
				stg_valid_q <= 1'b0;
			if (push_c)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q <= char_code;
			line_q <= line_select;
		end
		if (emit_c) begin
			stg_target_q <= emit_target_c;
			stg_value_q  <= emit_value_c;
			stg_hold_q   <= 13'd0;
		end else begin
			// sums stay below 4351 so no wrap
			stg_hold_q <= stg_hold_q + wait_add_c;
		end
		if (push_c) begin
			out_target_q <= stg_target_q;
			out_value_q  <= stg_value_q;
			out_hold_q   <= stg_hold_q;
			out_last_q   <= finish_c;
		end
	end

endmodule

`default_nettype wire

>>> hdl/char_lcd_nibble_sequencer.sv
// Character LCD nibble sequencer (HD44780 4-bit mode over a port expander).
// Input channel (in_valid/in_ready): command, char_code, line_select. Each command
// expands into 0 to 22 expander writes on the output channel (out_valid/out_ready):
// write_target, port_value (DB4-DB7 bits 0-3, RS bit 4, E bit 5), hold_us and
// last_write, which marks the final write of the command. Unused codes give no writes.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 is the
// enable pulse wait, index 1 the settle wait; cfg_ready is always high.
// One command at a time: an accepted command walks through its sequence table steps in
// order, five steps per enable pulse; in_ready is high only while the sequencer is idle.
// Each write is held in a pending register until the waits after it are summed, so
// it reaches the output register one write later; the last one leaves at the end.
// When the receiver stalls, the sequencer halts on its next write until the output
// register frees up; nothing is dropped. A new command is accepted while the final
// write of the previous one still waits in the output register.
// Reset clears the sequencer, port shadow and valids, and restores the waits to 40 us
// and 1600 us.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_sequencer import clns_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [2:0]  command,
	input  wire logic [7:0]  char_code,
	input  wire logic        line_select,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             write_target,
	output logic [5:0]       port_value,
	output logic [12:0]      hold_us,
	output logic             last_write,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [11:0] cfg_data
);

	ctl_cmd_t ctl_cmd;
	dp_sts_t  dp_sts;

	assign cfg_ready = 1'b1;

	clns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (command),
		.sts      (dp_sts),
		.cmd      (ctl_cmd)
	);

	clns_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.char_code    (char_code),
		.line_select  (line_select),
		.cmd          (ctl_cmd),
		.sts          (dp_sts),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_target (write_target),
		.port_value   (port_value),
		.hold_us      (hold_us),
		.last_write   (last_write)
	);

endmodule

`default_nettype wire
